// File: hdl/kcfp_pkg.sv
// shared types and codes of the kiss command frame parser
`default_nettype none

package kcfp_pkg;

   // widest callsign length count for any supported store size
   localparam int unsigned RUN_LEN_W = 6;

   localparam logic [7:0] FEND_BYTE = 8'hC0;
   localparam logic [7:0] CMD_BYTE  = 8'h00;
   localparam logic [7:0] TOKEN_LETTER_LO = 8'h41;
   localparam logic [7:0] TOKEN_LETTER_HI = 8'h48;
   localparam logic [7:0] TOKEN_DIGIT_LO  = 8'h31;

   localparam logic [1:0] KIND_COMMAND  = 2'd0;
   localparam logic [1:0] KIND_CALLSIGN = 2'd1;
   localparam logic [1:0] KIND_END      = 2'd2;

   localparam logic [3:0] CMD_UNDEFINED = 4'd8;

   localparam logic [1:0] ST_CLOSED     = 2'd0;
   localparam logic [1:0] ST_BAD_HEADER = 2'd1;
   localparam logic [1:0] ST_RAN_OUT    = 2'd2;

   // work handed from the front to the back for one input byte
   typedef struct packed {
      logic                 has_run;
      logic                 has_cmd;
      logic                 has_end;
      logic [3:0]           cmd_code;
      logic [1:0]           end_status;
      logic [RUN_LEN_W-1:0] run_len;
      logic                 overflow;
   } work_type;

   // callsign store write port
   typedef struct packed {
      logic                 en;
      logic [RUN_LEN_W-1:0] addr;
      logic [7:0]           data;
   } store_wr_type;

endpackage

`default_nettype wire

// File: hdl/kcfp_front.sv
// byte classifier and frame parse state of the kiss command frame parser
`default_nettype none

module kcfp_front #(
   parameter int unsigned CALLSIGN_MAX = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [7:0]            req_byte_value,
   input  wire                   req_first_byte,
   input  wire                   req_last_byte,
   output kcfp_pkg::work_type     push_work,
   output logic                  push_valid,
   input  wire                   queue_full,
   input  wire                   run_done,
   output kcfp_pkg::store_wr_type store_wr
);
   import kcfp_pkg::*;

   localparam logic [2:0] PH_NO_FRAME    = 3'd0;
   localparam logic [2:0] PH_FRAME_START = 3'd1;
   localparam logic [2:0] PH_GAP_INITIAL = 3'd2;
   localparam logic [2:0] PH_CALLSIGN    = 3'd3;
   localparam logic [2:0] PH_GAP         = 3'd4;
   localparam logic [2:0] PH_TOKEN       = 3'd5;
   localparam logic [2:0] PH_DONE        = 3'd6;

   localparam int unsigned LW = $clog2(CALLSIGN_MAX + 1);

   logic [2:0]    phase_ff, phase_in;
   logic [1:0]    tlen_ff, tlen_in;
   logic [7:0]    tfirst_ff, tfirst_in;
   logic [7:0]    tsecond_ff, tsecond_in;
   logic [LW-1:0] clen_ff, clen_in;
   logic          cover_ff, cover_in;
   logic [1:0]    cstat_ff, cstat_in;
   logic          run_busy_ff, run_busy_in;

   logic          accept;
   logic          printable;
   logic          is_fend;
   logic [2:0]    ph;
   logic [1:0]    tl;
   logic [7:0]    tf, ts;
   logic [LW-1:0] cl;
   logic          co;
   logic [1:0]    cs;
   logic          emit_run, emit_cmd;
   logic [3:0]    code;
   logic [1:0]    end_stat;

   assign req_stall = queue_full | run_busy_ff;
   assign accept    = req_valid & ~req_stall;
   assign printable = req_byte_value inside {[8'h21:8'h7E]};
   assign is_fend   = (req_byte_value == FEND_BYTE);

   // command decode of the held token
   always_comb begin
      code = CMD_UNDEFINED;
      if (tl == 2'd2 && tf inside {[TOKEN_LETTER_LO:TOKEN_LETTER_HI]} &&
          ts == tf - TOKEN_LETTER_LO + TOKEN_DIGIT_LO) begin
         code = 4'(tf - TOKEN_LETTER_LO);
      end
   end

   always_comb begin
      // new buffer restarts from the idle values
      ph = req_first_byte ? PH_NO_FRAME : phase_ff;
      tl = req_first_byte ? 2'd0 : tlen_ff;
      tf = req_first_byte ? 8'd0 : tfirst_ff;
      ts = req_first_byte ? 8'd0 : tsecond_ff;
      cl = req_first_byte ? '0 : clen_ff;
      co = req_first_byte ? 1'b0 : cover_ff;
      cs = req_first_byte ? ST_RAN_OUT : cstat_ff;

      phase_in   = ph;
      tlen_in    = tl;
      tfirst_in  = tf;
      tsecond_in = ts;
      clen_in    = cl;
      cover_in   = co;
      cstat_in   = cs;
      emit_run   = 1'b0;
      emit_cmd   = 1'b0;
      store_wr.en   = 1'b0;
      store_wr.addr = RUN_LEN_W'(cl);
      store_wr.data = req_byte_value;

      case (ph)
         PH_NO_FRAME: begin
            if (is_fend) begin
               phase_in = PH_FRAME_START;
            end else begin
               cstat_in = ST_BAD_HEADER;
               phase_in = PH_DONE;
            end
         end
         PH_FRAME_START: begin
            if (req_byte_value == CMD_BYTE) begin
               phase_in = PH_GAP_INITIAL;
            end else begin
               cstat_in = ST_BAD_HEADER;
               phase_in = PH_DONE;
            end
         end
         PH_GAP_INITIAL, PH_CALLSIGN: begin
            if (is_fend) begin
               emit_run = (ph == PH_CALLSIGN);
               cstat_in = ST_CLOSED;
               phase_in = PH_DONE;
            end else if (printable) begin
               phase_in = PH_CALLSIGN;
               if (cl < LW'(CALLSIGN_MAX)) begin
                  store_wr.en = 1'b1;
                  clen_in     = cl + 1'b1;
               end else begin
                  cover_in = 1'b1;
               end
            end else if (ph == PH_CALLSIGN) begin
               emit_run = 1'b1;
               phase_in = PH_GAP;
            end
         end
         PH_GAP, PH_TOKEN: begin
            if (is_fend) begin
               emit_cmd = (ph == PH_TOKEN);
               cstat_in = ST_CLOSED;
               phase_in = PH_DONE;
            end else if (printable) begin
               phase_in = PH_TOKEN;
               if (tl == 2'd0) tfirst_in = req_byte_value;
               if (tl == 2'd1) tsecond_in = req_byte_value;
               if (tl != 2'd3) tlen_in = tl + 2'd1;
            end else if (ph == PH_TOKEN) begin
               emit_cmd = 1'b1;
               phase_in = PH_GAP;
            end
            if (emit_cmd) begin
               tlen_in    = 2'd0;
               tfirst_in  = 8'd0;
               tsecond_in = 8'd0;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // status this byte leaves before the end-of-buffer reset
      end_stat = cstat_in;

      if (req_last_byte) begin
         phase_in   = PH_NO_FRAME;
         tlen_in    = 2'd0;
         tfirst_in  = 8'd0;
         tsecond_in = 8'd0;
         clen_in    = '0;
         cover_in   = 1'b0;
         cstat_in   = ST_RAN_OUT;
      end

      push_work.has_run    = emit_run;
      push_work.has_cmd    = emit_cmd;
      push_work.has_end    = req_last_byte;
      push_work.cmd_code   = code;
      push_work.end_status = end_stat;
      push_work.run_len    = RUN_LEN_W'(cl);
      push_work.overflow   = co;
      store_wr.en = store_wr.en & accept;
      push_valid  = accept & (emit_run | emit_cmd | req_last_byte);
   end

   always_comb begin
      run_busy_in = run_busy_ff;
      if (run_done) run_busy_in = 1'b0;
      if (push_valid && push_work.has_run) run_busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_NO_FRAME;
         tlen_ff     <= 2'd0;
         tfirst_ff   <= 8'd0;
         tsecond_ff  <= 8'd0;
         clen_ff     <= '0;
         cover_ff    <= 1'b0;
         cstat_ff    <= ST_RAN_OUT;
         run_busy_ff <= 1'b0;
      end else begin
         run_busy_ff <= run_busy_in;
         if (accept) begin
            phase_ff   <= phase_in;
            tlen_ff    <= tlen_in;
            tfirst_ff  <= tfirst_in;
            tsecond_ff <= tsecond_in;
            clen_ff    <= clen_in;
            cover_ff   <= cover_in;
            cstat_ff   <= cstat_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/kcfp_queue.sv
// two-entry work queue between the front and the back
`default_nettype none

module kcfp_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push_valid,
   input  kcfp_pkg::work_type push_work,
   output logic               full,
   input  wire                pop,
   output logic               not_empty,
   output kcfp_pkg::work_type pop_work
);
   import kcfp_pkg::*;

   work_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_work  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_valid;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push_valid) slot_ff[wr_ptr_ff] <= push_work;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/kcfp_back.sv
// result sequencer and callsign store of the kiss command frame parser
`default_nettype none

module kcfp_back #(
   parameter int unsigned CALLSIGN_MAX = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    work_ready,
   input  kcfp_pkg::work_type      work,
   output logic                   work_pop,
   input  kcfp_pkg::store_wr_type  store_wr,
   output logic                   run_done,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [1:0]             rsp_result_kind,
   output logic [3:0]             rsp_command_code,
   output logic [7:0]             rsp_callsign_char,
   output logic [1:0]             rsp_end_status,
   output logic                   rsp_callsign_truncated,
   output logic                   rsp_run_last
);
   import kcfp_pkg::*;

   localparam int unsigned AW = (CALLSIGN_MAX > 1) ? $clog2(CALLSIGN_MAX) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RUN    = 3'd1;
   localparam logic [2:0] S_RUNOUT = 3'd2;
   localparam logic [2:0] S_CMD    = 3'd3;
   localparam logic [2:0] S_END    = 3'd4;

   logic [7:0]           mem [CALLSIGN_MAX];
   logic [7:0]           rd_ff;
   logic [2:0]           state_ff, state_in;
   work_type             cur_ff;
   logic [RUN_LEN_W-1:0] idx_ff, idx_in;

   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           kind_ff, kind_in;
   logic [3:0]           cmd_ff, cmd_in;
   logic [7:0]           char_ff, char_in;
   logic [1:0]           stat_ff, stat_in;
   logic                 trunc_ff, trunc_in;
   logic                 last_ff, last_in;

   logic                 out_free;
   logic                 load;
   logic                 run_end;

   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign work_pop = (state_ff == S_IDLE) & work_ready;
   assign run_end  = (RUN_LEN_W'(idx_ff + 1'b1) == cur_ff.run_len);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      load     = 1'b0;
      run_done = 1'b0;
      kind_in  = kind_ff;
      cmd_in   = 4'd0;
      char_in  = 8'd0;
      stat_in  = 2'd0;
      trunc_in = 1'b0;
      last_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (work_ready) begin
               idx_in = '0;
               if (work.has_run) state_in = S_RUN;
               else if (work.has_cmd) state_in = S_CMD;
               else state_in = S_END;
            end
         end
         S_RUN: begin
            state_in = S_RUNOUT;
         end
         S_RUNOUT: begin
            if (out_free) begin
               load     = 1'b1;
               kind_in  = KIND_CALLSIGN;
               char_in  = rd_ff;
               trunc_in = cur_ff.overflow;
               last_in  = run_end & ~cur_ff.has_cmd & ~cur_ff.has_end;
               idx_in   = idx_ff + 1'b1;
               if (run_end) begin
                  run_done = 1'b1;
                  if (cur_ff.has_cmd) state_in = S_CMD;
                  else if (cur_ff.has_end) state_in = S_END;
                  else state_in = S_IDLE;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_CMD: begin
            if (out_free) begin
               load     = 1'b1;
               kind_in  = KIND_COMMAND;
               cmd_in   = cur_ff.cmd_code;
               last_in  = ~cur_ff.has_end;
               state_in = cur_ff.has_end ? S_END : S_IDLE;
            end
         end
         S_END: begin
            if (out_free) begin
               load     = 1'b1;
               kind_in  = KIND_END;
               stat_in  = cur_ff.end_status;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      out_valid_in = load | (out_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (store_wr.en) mem[store_wr.addr[AW-1:0]] <= store_wr.data;
      if (state_ff == S_RUN) rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (work_pop) cur_ff <= work;
      idx_ff <= idx_in;
      if (load) begin
         kind_ff  <= kind_in;
         cmd_ff   <= cmd_in;
         char_ff  <= char_in;
         stat_ff  <= stat_in;
         trunc_ff <= trunc_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_result_kind        = kind_ff;
   assign rsp_command_code       = cmd_ff;
   assign rsp_callsign_char      = char_ff;
   assign rsp_end_status         = stat_ff;
   assign rsp_callsign_truncated = trunc_ff;
   assign rsp_run_last           = last_ff;

endmodule

`default_nettype wire

// File: hdl/kiss_command_frame_parser.sv
// top level of the kiss command frame parser
//
// Takes a received buffer one byte per transfer and gives command, callsign
// byte and end-of-buffer results. A frame opens with 0xC0 0x00; the first
// printable word is the callsign, each later word a command token (A1, B2
// .. H8, letter and digit paired; anything else is undefined), and 0xC0
// closes the frame. The front accepts one byte per cycle while the two-entry
// work queue has room and no callsign is pending. Once a finished callsign
// is queued, input stalls until its last byte has been loaded into the
// output register: the back reads each callsign byte from the store, then
// loads it into the output register. The back takes a work entry from the
// queue while idle, then loads each command or end result. Results leave
// through an output register, so input keeps flowing while a result waits
// on rsp_stall until two work entries are queued behind it or a callsign
// is pending. rsp_run_last marks the last result of an input byte.
`default_nettype none

module kiss_command_frame_parser #(
   parameter int unsigned CALLSIGN_MAX = 16
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_byte_value,
   input  wire        req_first_byte,
   input  wire        req_last_byte,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [3:0] rsp_command_code,
   output logic [7:0] rsp_callsign_char,
   output logic [1:0] rsp_end_status,
   output logic       rsp_callsign_truncated,
   output logic       rsp_run_last
);
   import kcfp_pkg::*;

   work_type     push_work, pop_work;
   store_wr_type store_wr;
   logic         push_valid, queue_full, not_empty, work_pop, run_done;

   kcfp_front #(.CALLSIGN_MAX(CALLSIGN_MAX)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .push_work      (push_work),
      .push_valid     (push_valid),
      .queue_full     (queue_full),
      .run_done       (run_done),
      .store_wr       (store_wr)
   );

   kcfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_work  (push_work),
      .full       (queue_full),
      .pop        (work_pop),
      .not_empty  (not_empty),
      .pop_work   (pop_work)
   );

   kcfp_back #(.CALLSIGN_MAX(CALLSIGN_MAX)) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .work_ready             (not_empty),
      .work                   (pop_work),
      .work_pop               (work_pop),
      .store_wr               (store_wr),
      .run_done               (run_done),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_command_code       (rsp_command_code),
      .rsp_callsign_char      (rsp_callsign_char),
      .rsp_end_status         (rsp_end_status),
      .rsp_callsign_truncated (rsp_callsign_truncated),
      .rsp_run_last           (rsp_run_last)
   );

endmodule

`default_nettype wire

// File: bench/kiss_command_frame_parser_test.sv
// self-checking testbench for the kiss command frame parser
`default_nettype none

module kiss_command_frame_parser_test;
   import kcfp_pkg::*;

   localparam int unsigned CALLSIGN_LIMIT = 16;
   localparam logic [7:0] PRINT_LO = 8'h21;
   localparam logic [7:0] PRINT_HI = 8'h7E;
   localparam int HOLD_CYCLES = 400;

   typedef enum logic [2:0] {
      PHASE_NO_FRAME,
      PHASE_FRAME_START,
      PHASE_GAP_FIRST,
      PHASE_CALLSIGN,
      PHASE_GAP,
      PHASE_TOKEN,
      PHASE_DONE
   } parse_phase_type;

   typedef struct {
      logic [1:0] kind;
      logic [3:0] cmd;
      logic [7:0] ch;
      logic [1:0] status;
      logic       truncated;
      logic       run_last;
   } parse_result_type;

   typedef struct {
      logic [7:0] value;
      logic       first;
      logic       last;
   } byte_item_type;

   typedef logic [7:0] octet_queue_type[$];

   class frame_result_book_type;
      parse_phase_type  phase;
      logic [1:0]       tok_len;
      logic [7:0]       tok_first;
      logic [7:0]       tok_second;
      logic [7:0]       call_bytes[CALLSIGN_LIMIT];
      int               call_len;
      logic             call_cut;
      logic [1:0]       close_code;
      parse_result_type byte_run[$];
      parse_result_type results_due[$];
      int               mismatches;
      int               got_kind[3];
      int               cut_bytes;
      logic [8:0]       codes_seen;

      function new();
         mismatches = 0;
         cut_bytes = 0;
         codes_seen = '0;
         foreach (got_kind[i]) got_kind[i] = 0;
         clear();
      endfunction

      function void clear();
         phase = PHASE_NO_FRAME;
         tok_len = '0;
         tok_first = '0;
         tok_second = '0;
         call_len = 0;
         call_cut = 1'b0;
         close_code = ST_RAN_OUT;
      endfunction

      function parse_result_type make_result(logic [1:0] kind, logic [3:0] cmd,
                                             logic [7:0] ch, logic [1:0] status,
                                             logic truncated);
         parse_result_type r;
         r.kind = kind;
         r.cmd = cmd;
         r.ch = ch;
         r.status = status;
         r.truncated = truncated;
         r.run_last = 1'b0;
         return r;
      endfunction

      function void add_token(logic [7:0] value);
         if (tok_len == 2'd0) tok_first = value;
         else if (tok_len == 2'd1) tok_second = value;
         if (tok_len < 2'd3) tok_len++;
      endfunction

      function void add_callsign(logic [7:0] value);
         if (call_len < CALLSIGN_LIMIT) begin
            call_bytes[call_len] = value;
            call_len++;
         end else begin
            call_cut = 1'b1;
         end
      endfunction

      function void flush_callsign();
         for (int i = 0; i < call_len; i++)
            byte_run.insert(byte_run.size(),
                            make_result(KIND_CALLSIGN, '0, call_bytes[i], '0, call_cut));
      endfunction

      function void flush_token();
         logic [3:0] code;
         code = CMD_UNDEFINED;
         if (tok_len == 2'd2 && tok_first >= TOKEN_LETTER_LO && tok_first <= TOKEN_LETTER_HI
             && tok_second == tok_first - TOKEN_LETTER_LO + TOKEN_DIGIT_LO)
            code = tok_first[3:0] - TOKEN_LETTER_LO[3:0];
         byte_run.insert(byte_run.size(), make_result(KIND_COMMAND, code, '0, '0, 1'b0));
         tok_len = '0;
         tok_first = '0;
         tok_second = '0;
      endfunction

      function void parse_byte(logic [7:0] value, logic first, logic last);
         bit printable;
         printable = value >= PRINT_LO && value <= PRINT_HI;
         byte_run = {};
         if (first) clear();
         case (phase)
            PHASE_NO_FRAME: begin
               if (value == FEND_BYTE) begin
                  phase = PHASE_FRAME_START;
               end else begin
                  close_code = ST_BAD_HEADER;
                  phase = PHASE_DONE;
               end
            end
            PHASE_FRAME_START: begin
               if (value == CMD_BYTE) begin
                  phase = PHASE_GAP_FIRST;
               end else begin
                  close_code = ST_BAD_HEADER;
                  phase = PHASE_DONE;
               end
            end
            PHASE_GAP_FIRST: begin
               if (value == FEND_BYTE) begin
                  close_code = ST_CLOSED;
                  phase = PHASE_DONE;
               end else if (printable) begin
                  add_callsign(value);
                  phase = PHASE_CALLSIGN;
               end
            end
            PHASE_CALLSIGN: begin
               if (value == FEND_BYTE) begin
                  flush_callsign();
                  close_code = ST_CLOSED;
                  phase = PHASE_DONE;
               end else if (printable) begin
                  add_callsign(value);
               end else begin
                  flush_callsign();
                  phase = PHASE_GAP;
               end
            end
            PHASE_GAP: begin
               if (value == FEND_BYTE) begin
                  close_code = ST_CLOSED;
                  phase = PHASE_DONE;
               end else if (printable) begin
                  add_token(value);
                  phase = PHASE_TOKEN;
               end
            end
            PHASE_TOKEN: begin
               if (value == FEND_BYTE) begin
                  flush_token();
                  close_code = ST_CLOSED;
                  phase = PHASE_DONE;
               end else if (printable) begin
                  add_token(value);
               end else begin
                  flush_token();
                  phase = PHASE_GAP;
               end
            end
            default: phase = PHASE_DONE;
         endcase
         if (last) begin
            byte_run.insert(byte_run.size(),
                            make_result(KIND_END, '0, '0, close_code, 1'b0));
            clear();
         end
         if (byte_run.size() > 0) byte_run[byte_run.size() - 1].run_last = 1'b1;
         results_due = {results_due, byte_run};
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(parse_result_type got);
         parse_result_type want;
         if (results_due.size() == 0) begin
            $error("result kind %0d arrived with nothing outstanding", got.kind);
            mismatches++;
            return;
         end
         want = results_due.pop_front();
         compare_field("result_kind", want.kind, got.kind);
         compare_field("command_code", want.cmd, got.cmd);
         compare_field("callsign_char", want.ch, got.ch);
         compare_field("end_status", want.status, got.status);
         compare_field("callsign_truncated", want.truncated, got.truncated);
         compare_field("run_last", want.run_last, got.run_last);
         if (want.kind <= KIND_END) got_kind[want.kind]++;
         if (want.kind == KIND_COMMAND) codes_seen[want.cmd] = 1'b1;
         if (want.truncated) cut_bytes++;
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_byte_value;
   logic       req_first_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_result_kind;
   logic [3:0] rsp_command_code;
   logic [7:0] rsp_callsign_char;
   logic [1:0] rsp_end_status;
   logic       rsp_callsign_truncated;
   logic       rsp_run_last;

   frame_result_book_type book = new();
   byte_item_type         byte_plan[$];
   octet_queue_type       frame_bytes;
   int                    accepted_bytes = 0;
   parse_result_type      seen_result;

   kiss_command_frame_parser #(
      .CALLSIGN_MAX(CALLSIGN_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_byte_value(req_byte_value),
      .req_first_byte(req_first_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_command_code(rsp_command_code),
      .rsp_callsign_char(rsp_callsign_char),
      .rsp_end_status(rsp_end_status),
      .rsp_callsign_truncated(rsp_callsign_truncated),
      .rsp_run_last(rsp_run_last)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] any_separator();
      case ($urandom_range(0, 2))
         0: return 8'($urandom_range(8'h00, 8'h20));
         1: return 8'($urandom_range(8'h7F, 8'hBF));
         default: return 8'($urandom_range(8'hC1, 8'hFF));
      endcase
   endfunction

   function automatic logic [7:0] any_printable();
      return 8'($urandom_range(PRINT_LO, PRINT_HI));
   endfunction

   function automatic void append_byte(logic [7:0] value);
      frame_bytes.insert(frame_bytes.size(), value);
   endfunction

   task automatic commit_buffer(bit start_flag);
      int split;
      byte_item_type item;
      split = -1;
      if ($urandom_range(0, 24) == 0 && frame_bytes.size() > 2)
         split = $urandom_range(1, frame_bytes.size() - 1);
      foreach (frame_bytes[i]) begin
         item.value = frame_bytes[i];
         item.first = (i == 0 && start_flag) || i == split;
         item.last = i == frame_bytes.size() - 1;
         byte_plan.insert(byte_plan.size(), item);
      end
   endtask

   task automatic make_frame();
      int count;
      int style;
      logic [7:0] letter;
      frame_bytes = {};
      append_byte(FEND_BYTE);
      append_byte(CMD_BYTE);
      repeat ($urandom_range(0, 2)) append_byte(any_separator());
      style = $urandom_range(0, 9);
      if (style < 7) count = $urandom_range(1, 8);
      else if (style == 7) count = CALLSIGN_LIMIT;
      else count = $urandom_range(CALLSIGN_LIMIT + 1, CALLSIGN_LIMIT + 4);
      repeat (count) append_byte(any_printable());
      repeat ($urandom_range(0, 4)) begin
         repeat ($urandom_range(1, 2)) append_byte(any_separator());
         style = $urandom_range(0, 9);
         letter = TOKEN_LETTER_LO + 8'($urandom_range(0, 7));
         if (style < 6) begin
            append_byte(letter);
            append_byte(letter - TOKEN_LETTER_LO + TOKEN_DIGIT_LO);
         end else if (style < 8) begin
            append_byte(letter);
            append_byte(TOKEN_DIGIT_LO + 8'($urandom_range(0, 8)));
         end else begin
            repeat ($urandom_range(1, 5)) append_byte(any_printable());
         end
      end
      case ($urandom_range(0, 3))
         0: append_byte(FEND_BYTE);
         1: begin
            append_byte(any_separator());
            append_byte(FEND_BYTE);
            repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
         end
         2: append_byte(any_separator());
         default: ;
      endcase
   endtask

   task automatic make_noise();
      logic [7:0] second;
      frame_bytes = {};
      case ($urandom_range(0, 2))
         0: repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
         1: begin
            second = 8'($urandom_range(1, 255));
            append_byte(FEND_BYTE);
            append_byte(second);
            repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            append_byte(FEND_BYTE);
            append_byte(CMD_BYTE);
            repeat ($urandom_range(0, 2)) append_byte(any_separator());
            append_byte(FEND_BYTE);
            repeat ($urandom_range(0, 2)) append_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   task automatic build_stimulus();
      int target;
      // callsign and two commands between extreme separators, closed
      frame_bytes = '{8'hC0, 8'h00, 8'h20, 8'h21, 8'h7E, 8'h00, 8'h41, 8'h31,
                      8'hFF, 8'h48, 8'h38, 8'hC0};
      commit_buffer(1'b1);
      frame_bytes = '{8'h41, 8'h5A};
      commit_buffer(1'b0);
      frame_bytes = '{8'hC0, 8'h7F};
      commit_buffer(1'b1);
      frame_bytes = '{8'hC0};
      commit_buffer(1'b0);
      // one-byte callsign, undefined token, then a token cut off by the end of the buffer
      frame_bytes = '{8'hC0, 8'h00, 8'h4B, 8'h20, 8'h42, 8'h33, 8'h20, 8'h43};
      commit_buffer(1'b0);
      target = byte_plan.size() + 250;
      while (byte_plan.size() < target) begin
         if ($urandom_range(0, 99) < 85) make_frame();
         else make_noise();
         commit_buffer($urandom_range(0, 1) == 1);
      end
   endtask

   task automatic drive_plan();
      int burst_left;
      int gap;
      burst_left = 0;
      foreach (byte_plan[i]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         @(negedge clock);
         req_valid <= 1'b1;
         req_byte_value <= byte_plan[i].value;
         req_first_byte <= byte_plan[i].first;
         req_last_byte <= byte_plan[i].last;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         book.parse_byte(byte_plan[i].value, byte_plan[i].first, byte_plan[i].last);
         accepted_bytes++;
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.kind = rsp_result_kind;
         seen_result.cmd = rsp_command_code;
         seen_result.ch = rsp_callsign_char;
         seen_result.status = rsp_end_status;
         seen_result.truncated = rsp_callsign_truncated;
         seen_result.run_last = rsp_run_last;
         book.check_result(seen_result);
      end
   end

   initial begin
      int mode;
      int span;
      int tick;
      bit held;
      rsp_stall = 1'b0;
      held = 1'b0;
      mode = 0;
      span = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         // one long hold-off so the result path backs up into the input
         if (!held && accepted_bytes >= 40) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
         end
         span--;
         tick++;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(0, 99) < 40;
            2: rsp_stall <= (tick % 5) < 2;
            default: rsp_stall <= $urandom_range(0, 99) < 85;
         endcase
      end
   end

   initial begin
      #5000000;
      $display("kiss_command_frame_parser_test NOT OK");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_value = '0;
      req_first_byte = 1'b0;
      req_last_byte = 1'b0;
      build_stimulus();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      drive_plan();
      while (book.results_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d bytes sent; checked %0d command, %0d callsign byte and %0d end results",
               accepted_bytes, book.got_kind[KIND_COMMAND], book.got_kind[KIND_CALLSIGN],
               book.got_kind[KIND_END]);
      $display("command codes seen %b, %0d callsign bytes flagged as truncated",
               book.codes_seen, book.cut_bytes);
      if (book.mismatches == 0)
         $display("kiss_command_frame_parser_test OK");
      else
         $display("kiss_command_frame_parser_test NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
